FILE: src/swre_pkg.sv
// shared constants, types and token codes of the short window repeat encoder
// depends on nothing; every other file of the block uses it
package swre_pkg;

	localparam int WINDOW_BYTES = 32;
	localparam int MAX_MATCH = 8;
	localparam int HV_W = $clog2(WINDOW_BYTES + 1);
	localparam int FILL_W = $clog2(MAX_MATCH + 1);
	localparam int LEN_W = $clog2(MAX_MATCH + 1);
	localparam int DIST_W = $clog2(WINDOW_BYTES + 1);
	localparam int OFS_W = $clog2(WINDOW_BYTES);
	localparam int LM1_W = $clog2(MAX_MATCH);
	localparam int SEL_GROUP = 4;
	localparam int SEL_GROUPS = WINDOW_BYTES / SEL_GROUP;

	localparam logic [7:0] LITERAL_MARK = 8'hFF;
	localparam logic [1:0] SIZE_MATCH = 2'd1;
	localparam logic [1:0] SIZE_LITERAL = 2'd2;

	typedef logic [7:0] byte_t;
	typedef logic [MAX_MATCH-1:0][7:0] look_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [DIST_W-1:0] distance;
	} best_t;

	typedef struct packed {
		byte_t first;
		byte_t second;
		logic [1:0] size;
		logic last;
	} token_t;

endpackage

FILE: src/swre_ifs.sv
// handshake channels of the encoder: raw byte beats in, token beats out
// depends on swre_pkg for the byte type
interface swre_raw_if;
	logic valid;
	logic ready;
	swre_pkg::byte_t data_byte;
	logic final_byte;
	modport source(output valid, output data_byte, output final_byte, input ready);
	modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

interface swre_tok_if;
	logic valid;
	logic ready;
	swre_pkg::byte_t token_first;
	swre_pkg::byte_t token_second;
	logic [1:0] token_size;
	logic stream_end;
	modport source(output valid, output token_first, output token_second,
		output token_size, output stream_end, input ready);
	modport sink(input valid, input token_first, input token_second,
		input token_size, input stream_end, output ready);
endinterface

FILE: src/swre_cell.sv
// one history cell: holds a byte, takes its neighbor's byte on a shift
// and compares its byte against every lookahead byte; depends on swre_pkg
module swre_cell (
	input logic clk,
	input logic shift_en,
	input swre_pkg::byte_t shift_in,
	input swre_pkg::look_t look,
	output swre_pkg::byte_t held,
	output logic [swre_pkg::MAX_MATCH-1:0] eq
);
	import swre_pkg::*;

	byte_t held_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			held_q <= shift_in;
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_MATCH; j++) begin
			eq[j] = (held_q == look[j]);
		end
	end

	assign held = held_q;

endmodule

FILE: src/swre_select.sv
// match length per distance and a two-stage registered max tree
// depends on swre_pkg; fed by the compare bits of the cell row
module swre_select (
	input logic clk,
	input logic [swre_pkg::WINDOW_BYTES-1:0][swre_pkg::MAX_MATCH-1:0] cmp,
	input logic [swre_pkg::HV_W-1:0] hist_valid,
	input logic [swre_pkg::FILL_W-1:0] avail,
	output swre_pkg::best_t best
);
	import swre_pkg::*;

	logic [WINDOW_BYTES-1:0][MAX_MATCH-1:0] hit;
	logic [WINDOW_BYTES-1:0] dist_ok;
	logic [WINDOW_BYTES-1:0][LEN_W-1:0] len_d;
	best_t grp_c [SEL_GROUPS];
	best_t grp_s1 [SEL_GROUPS];
	best_t top_c;
	best_t best_s2;

	// distance gi+1 looks at cell gi-gj for lookahead byte gj
	for (genvar gi = 0; gi < WINDOW_BYTES; gi++) begin : g_dist
		assign dist_ok[gi] = (HV_W'(gi + 1) <= hist_valid);
		for (genvar gj = 0; gj < MAX_MATCH; gj++) begin : g_tap
			if (gj <= gi) begin : g_on
				assign hit[gi][gj] = cmp[gi-gj][gj] && (FILL_W'(gj) < avail);
			end else begin : g_off
				assign hit[gi][gj] = 1'b0;
			end
		end
	end

	// leading run of hits
	always_comb begin
		logic run;
		for (int i = 0; i < WINDOW_BYTES; i++) begin
			run = dist_ok[i];
			len_d[i] = '0;
			for (int j = 0; j < MAX_MATCH; j++) begin
				run = run & hit[i][j];
				len_d[i] = len_d[i] + LEN_W'(run);
			end
		end
	end

	// ascending scan with >= so the greater distance wins a tie
	always_comb begin
		for (int g = 0; g < SEL_GROUPS; g++) begin
			grp_c[g].len = '0;
			grp_c[g].distance = DIST_W'(g * SEL_GROUP + 1);
			for (int k = 0; k < SEL_GROUP; k++) begin
				if (len_d[g*SEL_GROUP+k] >= grp_c[g].len) begin
					grp_c[g].len = len_d[g*SEL_GROUP+k];
					grp_c[g].distance = DIST_W'(g * SEL_GROUP + k + 1);
				end
			end
		end
	end

	always_comb begin
		top_c = grp_s1[0];
		for (int g = 1; g < SEL_GROUPS; g++) begin
			if (grp_s1[g].len >= top_c.len) begin
				top_c = grp_s1[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < SEL_GROUPS; g++) begin
			grp_s1[g] <= grp_c[g];
		end
		best_s2 <= top_c;
	end

	assign best = best_s2;

endmodule

FILE: src/short_window_repeat_encoder.sv
// Short window LZ77 encoder. Raw bytes come in as beats on raw; tokens leave
// as beats on tokens. The first byte of a chunk leaves at once as a literal
// pair (255, byte). Later bytes collect in an 8-byte lookahead; once it is full,
// or on the final byte, the longest earlier match within the last 32 bytes is
// looked up (ties go to the greater distance) and sent as one match byte
// (len-1) | ((32-dist)<<3), or as a literal pair when nothing matches. The
// final byte flushes the lookahead and stream_end marks the chunk's last
// token; the encoder then starts over for the next chunk. A byte that does
// not fill the lookahead leaves the encoder idle and ready for the next byte.
// A byte that fills it starts a search: the registered max tree (S_SRCH1,
// S_SRCH2), then S_TOKEN loads the token register once it is free, then
// S_SHIFT shifts the history row by one cell per byte the token covers (L,
// 1 to 8). A final byte does the same, and each further token of the flush
// runs again from S_SRCH1. No clearing pass after reset.
// depends on swre_pkg, swre_ifs, swre_cell and swre_select
module short_window_repeat_encoder (
	input logic clk,
	input logic arst_n,
	swre_raw_if.sink raw,
	swre_tok_if.source tokens
);
	import swre_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SRCH1 = 5'b00010,
		S_SRCH2 = 5'b00100,
		S_TOKEN = 5'b01000,
		S_SHIFT = 5'b10000
	} state_t;

	state_t state_q;
	look_t look_q;
	logic [FILL_W-1:0] fill_q;
	logic [HV_W-1:0] hist_valid_q;
	logic first_q;
	logic flush_q;
	logic [LEN_W-1:0] cnt_q;
	logic out_valid_q;
	token_t tok_q;

	// history row: cell 0 holds the newest byte
	logic [WINDOW_BYTES-1:0][7:0] hist_byte;
	logic [WINDOW_BYTES-1:0][MAX_MATCH-1:0] cmp;
	best_t best;

	logic accept;
	logic out_free;
	logic hist_shift;
	byte_t hist_in;
	logic ld_first;
	logic ld_tok;
	logic lit;
	logic [LEN_W-1:0] consume;
	logic [LEN_W-1:0] len_m1;
	logic [DIST_W-1:0] dist_ofs;
	token_t tok_c;

	assign accept = raw.valid && raw.ready;
	assign out_free = !out_valid_q || tokens.ready;
	// a first byte needs the token register free right away
	assign raw.ready = (state_q == S_IDLE) && (first_q || !out_valid_q);

	assign ld_first = accept && !first_q;
	assign ld_tok = (state_q == S_TOKEN) && out_free;

	// the history shifts on a chunk's first byte, unless it is final, and on each consumed byte
	assign hist_shift = (state_q == S_SHIFT) || (ld_first && !raw.final_byte);
	assign hist_in = (state_q == S_IDLE) ? raw.data_byte : look_q[0];

	for (genvar gk = 0; gk < WINDOW_BYTES; gk++) begin : g_cell
		if (gk == 0) begin : g_head
			swre_cell u_cell (
				.clk(clk),
				.shift_en(hist_shift),
				.shift_in(hist_in),
				.look(look_q),
				.held(hist_byte[gk]),
				.eq(cmp[gk])
			);
		end else begin : g_body
			swre_cell u_cell (
				.clk(clk),
				.shift_en(hist_shift),
				.shift_in(hist_byte[gk-1]),
				.look(look_q),
				.held(hist_byte[gk]),
				.eq(cmp[gk])
			);
		end
	end

	swre_select u_select (
		.clk(clk),
		.cmp(cmp),
		.hist_valid(hist_valid_q),
		.avail(fill_q),
		.best(best)
	);

	// token built from the tree result
	assign lit = (best.len == '0);
	assign consume = lit ? LEN_W'(1) : best.len;
	assign len_m1 = best.len - LEN_W'(1);
	assign dist_ofs = DIST_W'(WINDOW_BYTES) - best.distance;

	always_comb begin
		if (ld_first) begin
			tok_c.first = LITERAL_MARK;
			tok_c.second = raw.data_byte;
			tok_c.size = SIZE_LITERAL;
			tok_c.last = raw.final_byte;
		end else if (lit) begin
			tok_c.first = LITERAL_MARK;
			tok_c.second = look_q[0];
			tok_c.size = SIZE_LITERAL;
			tok_c.last = flush_q && (consume == LEN_W'(fill_q));
		end else begin
			tok_c.first = {dist_ofs[OFS_W-1:0], len_m1[LM1_W-1:0]};
			tok_c.second = '0;
			tok_c.size = SIZE_MATCH;
			tok_c.last = flush_q && (consume == LEN_W'(fill_q));
		end
	end

	// lookahead bytes: appended at the fill point, shifted out at the head
	always_ff @(posedge clk) begin
		if (accept && first_q) begin
			look_q[fill_q[LM1_W-1:0]] <= raw.data_byte;
		end else if (state_q == S_SHIFT) begin
			for (int j = 0; j < MAX_MATCH - 1; j++) begin
				look_q[j] <= look_q[j+1];
			end
		end
	end

	// token register payload
	always_ff @(posedge clk) begin
		if (ld_first || ld_tok) begin
			tok_q <= tok_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_first || ld_tok) begin
			out_valid_q <= 1'b1;
		end else if (tokens.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			hist_valid_q <= '0;
			first_q <= 1'b0;
			flush_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && !first_q) begin
						// a final first byte leaves everything in reset state
						if (!raw.final_byte) begin
							first_q <= 1'b1;
							hist_valid_q <= HV_W'(1);
						end
					end else if (accept) begin
						fill_q <= fill_q + FILL_W'(1);
						if (raw.final_byte) begin
							flush_q <= 1'b1;
							state_q <= S_SRCH1;
						end else if (fill_q + FILL_W'(1) == FILL_W'(MAX_MATCH)) begin
							state_q <= S_SRCH1;
						end
					end
				end
				S_SRCH1: begin
					state_q <= S_SRCH2;
				end
				S_SRCH2: begin
					state_q <= S_TOKEN;
				end
				S_TOKEN: begin
					if (out_free) begin
						cnt_q <= consume;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					fill_q <= fill_q - FILL_W'(1);
					cnt_q <= cnt_q - LEN_W'(1);
					if (hist_valid_q != HV_W'(WINDOW_BYTES)) begin
						hist_valid_q <= hist_valid_q + HV_W'(1);
					end
					if (cnt_q == LEN_W'(1)) begin
						if (flush_q && fill_q == FILL_W'(1)) begin
							// chunk done: back to the reset state
							fill_q <= '0;
							hist_valid_q <= '0;
							first_q <= 1'b0;
							flush_q <= 1'b0;
							state_q <= S_IDLE;
						end else if (flush_q) begin
							state_q <= S_SRCH1;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign tokens.valid = out_valid_q;
	assign tokens.token_first = tok_q.first;
	assign tokens.token_second = tok_q.second;
	assign tokens.token_size = tok_q.size;
	assign tokens.stream_end = tok_q.last;

endmodule

FILE: src/swre_chk.sv
// port-level checks of the encoder and the bind that attaches them
// depends on swre_pkg and on the top level's ports
module swre_chk (
	input logic clk,
	input logic arst_n,
	input logic raw_valid,
	input logic raw_ready,
	input logic raw_final,
	input logic tok_valid,
	input logic tok_ready,
	input swre_pkg::byte_t tok_first,
	input swre_pkg::byte_t tok_second,
	input logic [1:0] tok_size,
	input logic tok_end
);
	import swre_pkg::*;

	// only the two token sizes exist
	a_size_code: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (tok_size == SIZE_MATCH || tok_size == SIZE_LITERAL))
		else $error("token size code out of range");

	// a literal pair always opens with the marker byte
	a_lit_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && tok_size == SIZE_LITERAL) |-> (tok_first == LITERAL_MARK))
		else $error("literal beat without marker byte");

	// a match token carries no second byte
	a_match_second: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && tok_size == SIZE_MATCH) |-> (tok_second == '0))
		else $error("match beat with nonzero second byte");

	// a final byte always starts work that holds off the next byte
	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(raw_valid && raw_ready && raw_final) |=> !raw_ready)
		else $error("input taken right after a final byte");

	// a stalled token beat holds
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && !tok_ready) |=> (tok_valid && $stable(tok_first)
			&& $stable(tok_second) && $stable(tok_size) && $stable(tok_end)))
		else $error("token beat changed while stalled");

endmodule

bind short_window_repeat_encoder swre_chk u_swre_chk (
	.clk(clk),
	.arst_n(arst_n),
	.raw_valid(raw.valid),
	.raw_ready(raw.ready),
	.raw_final(raw.final_byte),
	.tok_valid(tokens.valid),
	.tok_ready(tokens.ready),
	.tok_first(tokens.token_first),
	.tok_second(tokens.token_second),
	.tok_size(tokens.token_size),
	.tok_end(tokens.stream_end)
);
